// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Whenever trig holds, cond must hold at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== design/lbp_pkg.sv =====
// Package with the constants and types of the LRU buffer pool.
package lbp_pkg;

    localparam int SLOTS = 16;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_TOUCH   = 2'd1;
    localparam logic [1:0] OP_DEMOTE  = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_MRU  = 2'd1;
    localparam logic [1:0] MODE_LRU  = 2'd2;

    typedef struct packed {
        logic [15:0]   tag_table;
        logic [31:0]   tag_page;
        logic          pinned;
        logic [SW-1:0] rank;
    } t_entry;

endpackage

// ===== design/lru_buffer_pool_with_pinning_top.sv =====
// Buffer pool of page frames with LRU replacement and pinning, top level.
//
// One command word enters when start is high and busy is low: a page request
// (table and page tag, optional pin), or touch, demote or unpin of one slot.
// Exactly one result word follows, shown for one cycle with o_done high; the
// receiver cannot hold it off. Busy drops in the cycle that o_done is high,
// so the next command may be accepted while the result is on the ports.
// Frame tags, pinned bits and ranks live in one synchronous memory of SLOTS
// entries, read one entry a cycle; valid bits and a per-entry written bit are
// flip-flops, and an entry never written reads as unpinned with rank equal to
// its slot number. A request scans all SLOTS entries (state S_SCAN, then
// S_DRAIN), decides in S_DECIDE, then a read-modify-write pass over all
// entries rewrites the ranks (S_UPD, then S_UDRAIN) before o_done. Touch,
// demote and unpin read their slot once instead of scanning, then pass
// through S_DECIDE and the rewrite pass. A request hit without pin and a
// full pool skip the rewrite pass, as do a touch of a pinned frame, a demote
// that moves nothing and any slot command with an out-of-range slot. One
// command is worked on at a time; the frame memory has a single read and a
// single write port.
// Reset clears valid and written bits at once, so no clearing pass is needed.
module lru_buffer_pool_with_pinning_top
    import lbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_table_id,
    input  logic [31:0] i_page_index,
    input  logic        i_pin_request,
    input  logic [3:0]  i_slot_in,
    output logic        o_done,
    output logic [3:0]  o_slot_out,
    output logic [1:0]  o_status,
    output logic        o_flush_needed,
    output logic [15:0] o_evicted_table,
    output logic [31:0] o_evicted_page
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_UPD    = 3'd4;
    localparam logic [2:0] S_UDRAIN = 3'd5;

    localparam logic [SW-1:0] LAST   = SW'(SLOTS - 1);
    localparam logic [SW-1:0] TOP_RK = SW'(SLOTS - 1);

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    logic [2:0]       r_state;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_written;
    logic [SW-1:0]    r_cnt;
    logic             r_rd_vld;
    logic [SW-1:0]    r_rd_addr;

    logic [1:0]       r_op;
    logic [15:0]      r_tbl;
    logic [31:0]      r_pg;
    logic             r_pin;
    logic [3:0]       r_slot_in;
    logic             r_inr;
    logic [SW-1:0]    r_tgt;

    logic             r_hit;
    logic [SW-1:0]    r_hit_idx;
    logic             r_vic;
    logic [SW-1:0]    r_vic_idx;
    logic [SW-1:0]    r_vic_rank;
    logic             r_vic_valid;
    logic [15:0]      r_vic_tbl;
    logic [31:0]      r_vic_pg;
    logic             r_tgt_pin;

    logic [1:0]       r_mode;
    logic             r_set_tag;
    logic             r_wr_pin;
    logic             r_pin_val;

    logic             r_done;
    logic [3:0]       r_slot_out;
    logic [1:0]       r_status;
    logic             r_flush;
    logic [15:0]      r_ev_tbl;
    logic [31:0]      r_ev_pg;

    logic             rd_en;
    logic [SW-1:0]    rd_addr;
    logic             wr_en;
    t_entry           wdata;
    logic             eff_pin;
    logic [SW-1:0]    eff_rank;
    logic             accept;
    logic             in_range;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign in_range = (32'(i_slot_in) < SLOTS);

    // Entries never written read as unpinned, ranked by slot number.
    assign eff_pin  = r_written[r_rd_addr] ? r_rdata.pinned : 1'b0;
    assign eff_rank = r_written[r_rd_addr] ? r_rdata.rank : r_rd_addr;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_cnt;
        if (r_state == S_SCAN) begin
            rd_en   = 1'b1;
            rd_addr = (r_op == OP_REQUEST) ? r_cnt : r_tgt;
        end else if (r_state == S_UPD) begin
            rd_en = 1'b1;
        end
    end

    always_comb begin
        wr_en        = r_rd_vld && (r_state == S_UPD || r_state == S_UDRAIN);
        wdata        = r_rdata;
        wdata.pinned = eff_pin;
        wdata.rank   = eff_rank;
        if (r_rd_addr == r_tgt) begin
            if (r_mode == MODE_MRU) begin
                wdata.rank = TOP_RK;
            end else if (r_mode == MODE_LRU) begin
                wdata.rank = '0;
            end
            if (r_set_tag) begin
                wdata.tag_table = r_tbl;
                wdata.tag_page  = r_pg;
            end
            if (r_wr_pin) begin
                wdata.pinned = r_pin_val;
            end
        end else begin
            if (r_mode == MODE_MRU && eff_rank > r_vic_rank) begin
                wdata.rank = eff_rank - 1'b1;
            end else if (r_mode == MODE_LRU && eff_rank < r_vic_rank) begin
                wdata.rank = eff_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_rd_addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_written <= '0;
            r_rd_vld  <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_rd_vld  <= rd_en;
            r_rd_addr <= rd_addr;
            r_done    <= 1'b0;
            if (wr_en) begin
                r_written[r_rd_addr] <= 1'b1;
            end

            // Scan data: hit search and victim search for requests,
            // or the addressed frame's rank and pin for slot commands.
            if (r_rd_vld && (r_state == S_SCAN || r_state == S_DRAIN)) begin
                if (r_op == OP_REQUEST) begin
                    if (!r_hit && r_valid[r_rd_addr] && r_rdata.tag_table == r_tbl &&
                        r_rdata.tag_page == r_pg) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_rd_addr;
                    end
                    if (!eff_pin && (!r_vic || eff_rank < r_vic_rank)) begin
                        r_vic       <= 1'b1;
                        r_vic_idx   <= r_rd_addr;
                        r_vic_rank  <= eff_rank;
                        r_vic_valid <= r_valid[r_rd_addr];
                        r_vic_tbl   <= r_rdata.tag_table;
                        r_vic_pg    <= r_rdata.tag_page;
                    end
                end else begin
                    r_vic_rank <= eff_rank;
                    r_tgt_pin  <= eff_pin;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_operation;
                        r_tbl     <= i_table_id;
                        r_pg      <= i_page_index;
                        r_pin     <= i_pin_request;
                        r_slot_in <= i_slot_in;
                        r_inr     <= in_range;
                        r_tgt     <= SW'(i_slot_in);
                        r_hit     <= 1'b0;
                        r_vic     <= 1'b0;
                        r_cnt     <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_op != OP_REQUEST || r_cnt == LAST) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_cnt      <= '0;
                    r_mode     <= MODE_NONE;
                    r_set_tag  <= 1'b0;
                    r_wr_pin   <= 1'b0;
                    r_pin_val  <= 1'b0;
                    r_slot_out <= r_slot_in;
                    r_status   <= ST_HIT;
                    r_flush    <= 1'b0;
                    r_ev_tbl   <= '0;
                    r_ev_pg    <= '0;
                    r_state    <= S_IDLE;
                    r_done     <= 1'b1;
                    case (r_op)
                        OP_REQUEST: begin
                            if (r_hit) begin
                                r_slot_out <= 4'(r_hit_idx);
                                if (r_pin) begin
                                    r_tgt     <= r_hit_idx;
                                    r_wr_pin  <= 1'b1;
                                    r_pin_val <= 1'b1;
                                    r_state   <= S_UPD;
                                    r_done    <= 1'b0;
                                end
                            end else if (r_vic) begin
                                r_slot_out         <= 4'(r_vic_idx);
                                r_status           <= ST_MISS;
                                r_flush            <= r_vic_valid;
                                r_ev_tbl           <= r_vic_valid ? r_vic_tbl : 16'd0;
                                r_ev_pg            <= r_vic_valid ? r_vic_pg : 32'd0;
                                r_valid[r_vic_idx] <= 1'b1;
                                r_tgt              <= r_vic_idx;
                                r_mode             <= MODE_MRU;
                                r_set_tag          <= 1'b1;
                                r_wr_pin           <= 1'b1;
                                r_pin_val          <= r_pin;
                                r_state            <= S_UPD;
                                r_done             <= 1'b0;
                            end else begin
                                r_slot_out <= 4'd0;
                                r_status   <= ST_FULL;
                            end
                        end
                        OP_TOUCH: begin
                            if (r_inr && !r_tgt_pin) begin
                                r_mode  <= MODE_MRU;
                                r_state <= S_UPD;
                                r_done  <= 1'b0;
                            end
                        end
                        OP_DEMOTE: begin
                            if (r_inr && r_valid[r_tgt] && !r_tgt_pin) begin
                                r_mode  <= MODE_LRU;
                                r_state <= S_UPD;
                                r_done  <= 1'b0;
                            end
                        end
                        OP_UNPIN: begin
                            if (r_inr) begin
                                r_mode   <= MODE_MRU;
                                r_wr_pin <= 1'b1;
                                r_state  <= S_UPD;
                                r_done   <= 1'b0;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_UPD: begin
                    if (r_cnt == LAST) begin
                        r_state <= S_UDRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_UDRAIN: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_slot_out      = r_slot_out;
    assign o_status        = r_status;
    assign o_flush_needed  = r_flush;
    assign o_evicted_table = r_ev_tbl;
    assign o_evicted_page  = r_ev_pg;

endmodule

// ===== design/lbp_checker.sv =====
// Port-level checker for the LRU buffer pool, bound to the top level.
`include "assert_macros.svh"

module lbp_checker
    import lbp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [3:0]  o_slot_out,
    input logic [1:0]  o_status,
    input logic        o_flush_needed,
    input logic [15:0] o_evicted_table,
    input logic [31:0] o_evicted_page
);

    logic flush_ok;
    logic no_flush_ok;
    logic full_ok;
    logic accepted;

    assign flush_ok    = !(o_done && o_flush_needed) || (o_status == ST_MISS);
    assign no_flush_ok = !(o_done && !o_flush_needed) ||
                         (o_evicted_table == 16'd0 && o_evicted_page == 32'd0);
    assign full_ok     = !(o_done && o_status == ST_FULL) ||
                         (o_slot_out == 4'd0 && !o_flush_needed);
    assign accepted    = start && !busy;

    // A flush is only reported for a miss that evicted a valid page.
    `ASSERT_ALWAYS(a_flush_on_miss, i_clk, i_rst_n, flush_ok, "flush without miss")

    // Without a flush the evicted tag reads as zero.
    `ASSERT_ALWAYS(a_no_flush_zero, i_clk, i_rst_n, no_flush_ok, "evicted tag not cleared")

    // A full pool reports slot zero and no flush.
    `ASSERT_ALWAYS(a_full_clean, i_clk, i_rst_n, full_ok, "full result not clean")

    // An accepted command keeps the block busy in the next cycle.
    `ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, accepted, busy && !o_done, "no busy")

    // Each result strobe is a single cycle long.
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result strobe too long")

endmodule

bind lru_buffer_pool_with_pinning_top lbp_checker u_lbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_slot_out      (o_slot_out),
    .o_status        (o_status),
    .o_flush_needed  (o_flush_needed),
    .o_evicted_table (o_evicted_table),
    .o_evicted_page  (o_evicted_page)
);
